FILE: src/dedf_pkg.sv
// Package for the depth edge darkening filter: item structs, register codes
// and fixed arithmetic constants. Depends on nothing.
`timescale 1ns / 1ps

package dedf_pkg;

    localparam int DEPTH_W     = 24;
    localparam int COLOR_W     = 32;
    localparam int CFG_W       = 11;
    localparam int SCAN_W      = 11;
    localparam int CFG_INDEX_W = 2;
    localparam int GAIN_W      = 7;

    // Register indexes of the configuration port.
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SCAN_COUNT  = 2'd1;

    // Reset values of the registers.
    localparam int RESET_SCAN_LENGTH = 256;
    localparam logic [SCAN_W-1:0] RESET_SCAN_COUNT = 11'd256;

    // Laplacian clamp window and gain offset, in depth units (8 fraction bits).
    localparam logic signed [9:0]  T_MIN       = -10'sd128;
    localparam logic signed [9:0]  T_MAX       = 10'sd384;
    localparam logic signed [11:0] GAIN_OFFSET = 12'sd1032;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [COLOR_W-1:0] color;
        logic               pad;
    } t_in_item;

    typedef struct packed {
        logic [COLOR_W-1:0] shaded_color;
        logic               frame_end;
    } t_out_item;

endpackage

FILE: src/dedf_ram.sv
// Generic RAM with one write port and two registered read ports.
// Read data is the old content when a read and a write meet at one address.
`timescale 1ns / 1ps

module dedf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_a_addr,
    input  logic [ADDR_W-1:0] i_rd_b_addr,
    output logic [WIDTH-1:0]  o_rd_a_data,
    output logic [WIDTH-1:0]  o_rd_b_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_a;
    logic [WIDTH-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_a_addr];
            r_rd_b <= r_mem[i_rd_b_addr];
        end
    end

    assign o_rd_a_data = r_rd_a;
    assign o_rd_b_data = r_rd_b;

endmodule

FILE: src/depth_edge_darken_filter.sv
// Depth edge darkening filter, top level; uses dedf_pkg and dedf_ram.
// A result passes the stage 1, 2 and 3 registers into the output register once the
// item that completes it is accepted. Throughput: one item per cycle unless stalled.
// Reset (synchronous, active low) clears position, scan counter, registers to
// their defaults and all pipeline valid bits; line RAM contents need no clearing.
`timescale 1ns / 1ps

module depth_edge_darken_filter
    import dedf_pkg::*;
#(
    parameter int MAX_SCAN = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input item channel.
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_in_stall,
    // Result item channel.
    output logic                   o_out_valid,
    output t_out_item              o_out_data,
    input  logic                   i_out_stall,
    // Configuration write channel.
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    output logic                   o_cfg_ready
);

    localparam int POS_W      = $clog2(MAX_SCAN);
    localparam int RESET_LAST =
        (RESET_SCAN_LENGTH > MAX_SCAN ? MAX_SCAN : RESET_SCAN_LENGTH) - 1;

    // ------------------------------------------------------------------
    // Stage 0: frame position, configuration and line RAM access.
    // ------------------------------------------------------------------
    // The whole pipeline moves as one. It freezes only when a finished
    // result sits in the output register and the consumer stalls it.
    logic w_en;
    logic w_acc;
    logic w_flush;
    logic w_take;
    logic w_wr;
    logic w_emit;
    logic w_last_pos;
    logic [POS_W-1:0] w_pr;

    logic [POS_W-1:0]  r_pos;
    logic [SCAN_W-1:0] r_scan;
    logic [POS_W-1:0]  r_last_pos;
    logic [SCAN_W-1:0] r_cnt;

    logic r_out_v;

    assign w_en       = !(r_out_v && i_out_stall);
    assign o_in_stall = !w_en;
    assign o_cfg_ready = 1'b1;

    assign w_acc      = i_in_valid && w_en;
    // Once the scan counter reaches the scan count, every item is a flush
    // item that pushes out one pixel of the last scan.
    assign w_flush    = (r_scan >= r_cnt);
    // A pad item in a normal scan is dropped without touching any state.
    assign w_take     = w_acc && (w_flush || !i_in_data.pad);
    // Depth and color are stored for every real pixel, flush items store nothing.
    assign w_wr       = w_acc && !w_flush && !i_in_data.pad;
    // The first scan only fills the lines; in later scans every item taken emits one pixel.
    assign w_emit     = w_take && (r_scan != '0);
    assign w_last_pos = (r_pos == r_last_pos);
    // Right neighbor, clamped into the scan.
    assign w_pr       = w_last_pos ? r_pos : r_pos + POS_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_scan     <= '0;
            r_last_pos <= POS_W'(RESET_LAST);
            r_cnt      <= RESET_SCAN_COUNT;
        end else if (i_cfg_valid && (i_cfg_index == CFG_SCAN_LENGTH)) begin
            // The effective scan length is clamped to one up to the line size.
            if (i_cfg_data == '0) begin
                r_last_pos <= '0;
            end else if (int'(i_cfg_data) > MAX_SCAN) begin
                r_last_pos <= POS_W'(MAX_SCAN - 1);
            end else begin
                r_last_pos <= POS_W'(i_cfg_data - CFG_W'(1));
            end
            r_pos  <= '0;
            r_scan <= '0;
        end else if (i_cfg_valid && (i_cfg_index == CFG_SCAN_COUNT)) begin
            // A scan count of zero acts as one.
            r_cnt  <= (i_cfg_data == '0) ? SCAN_W'(1) : i_cfg_data;
            r_pos  <= '0;
            r_scan <= '0;
        end else if (w_take) begin
            if (w_last_pos) begin
                r_pos  <= '0;
                r_scan <= w_flush ? '0 : r_scan + SCAN_W'(1);
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    // Two depth banks alternate by scan parity: the bank of the current
    // scan's parity holds the scan before last and is overwritten with the
    // incoming scan, the other bank holds the previous scan. Both read
    // ports of both banks see the same addresses; stage 1 picks the roles.
    logic [DEPTH_W-1:0] w_b0_a;
    logic [DEPTH_W-1:0] w_b0_b;
    logic [DEPTH_W-1:0] w_b1_a;
    logic [DEPTH_W-1:0] w_b1_b;
    logic [COLOR_W-1:0] w_col_rd;

    dedf_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_SCAN)
    ) u_depth_bank0 (
        .i_clk       (i_clk),
        .i_rd_en     (w_en),
        .i_wr_en     (w_wr && !r_scan[0]),
        .i_wr_addr   (r_pos),
        .i_wr_data   (i_in_data.depth),
        .i_rd_a_addr (w_pr),
        .i_rd_b_addr (r_pos),
        .o_rd_a_data (w_b0_a),
        .o_rd_b_data (w_b0_b)
    );

    dedf_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_SCAN)
    ) u_depth_bank1 (
        .i_clk       (i_clk),
        .i_rd_en     (w_en),
        .i_wr_en     (w_wr && r_scan[0]),
        .i_wr_addr   (r_pos),
        .i_wr_data   (i_in_data.depth),
        .i_rd_a_addr (w_pr),
        .i_rd_b_addr (r_pos),
        .o_rd_a_data (w_b1_a),
        .o_rd_b_data (w_b1_b)
    );

    // The color line holds the previous scan; the read returns the old
    // color before the new pixel replaces it.
    dedf_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (MAX_SCAN)
    ) u_color_line (
        .i_clk       (i_clk),
        .i_rd_en     (w_en),
        .i_wr_en     (w_wr),
        .i_wr_addr   (r_pos),
        .i_wr_data   (i_in_data.color),
        .i_rd_a_addr (r_pos),
        .i_rd_b_addr (r_pos),
        .o_rd_a_data (),
        .o_rd_b_data (w_col_rd)
    );

    // ------------------------------------------------------------------
    // Stage 1: neighbor selection and pairwise sums.
    // ------------------------------------------------------------------
    logic               r1_v;
    logic               r1_par;
    logic               r1_second;
    logic               r1_flush;
    logic               r1_p0;
    logic               r1_fe;
    logic [DEPTH_W-1:0] r1_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_par    <= r_scan[0];
            r1_second <= (r_scan == SCAN_W'(1));
            r1_flush  <= w_flush;
            r1_p0     <= (r_pos == '0);
            r1_fe     <= w_flush && w_last_pos;
            r1_depth  <= i_in_data.depth;
        end
    end

    logic [DEPTH_W-1:0] w_c;
    logic [DEPTH_W-1:0] w_right;
    logic [DEPTH_W-1:0] w_left;
    logic [DEPTH_W-1:0] w_up;
    logic [DEPTH_W-1:0] w_dn;
    logic [DEPTH_W-1:0] r_cleft;

    always_comb begin
        w_c     = r1_par ? w_b0_b : w_b1_b;
        w_right = r1_par ? w_b0_a : w_b1_a;
        // At the top of the frame the missing upper scan is the center scan.
        w_up    = r1_second ? w_c : (r1_par ? w_b1_b : w_b0_b);
        // During the flush scan the missing lower scan is the center scan.
        w_dn    = r1_flush ? w_c : r1_depth;
        // The left neighbor is the center of the pixel just before; at the
        // start of a scan it is clamped to the center itself.
        w_left  = r1_p0 ? w_c : r_cleft;
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r1_v) begin
            r_cleft <= w_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: Laplacian, clamp and gain.
    // ------------------------------------------------------------------
    logic                 r2_v;
    logic [DEPTH_W+1:0]   r2_c4;
    logic [DEPTH_W:0]     r2_vert;
    logic [DEPTH_W:0]     r2_horz;
    logic [COLOR_W-1:0]   r2_color;
    logic                 r2_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_c4    <= {w_c, 2'b00};
            r2_vert  <= (DEPTH_W + 1)'(w_up) + (DEPTH_W + 1)'(w_dn);
            r2_horz  <= (DEPTH_W + 1)'(w_left) + (DEPTH_W + 1)'(w_right);
            r2_color <= w_col_rd;
            r2_fe    <= r1_fe;
        end
    end

    logic signed [DEPTH_W+3:0] w_t;
    logic signed [9:0]         w_tc;
    logic signed [11:0]        w_gnum;
    logic [GAIN_W-1:0]         w_gain;

    always_comb begin
        w_t = $signed({2'b00, r2_c4}) - $signed({3'b000, r2_vert})
              - $signed({3'b000, r2_horz});
        priority if (w_t < (DEPTH_W + 4)'(T_MIN)) begin
            w_tc = T_MIN;
        end else if (w_t > (DEPTH_W + 4)'(T_MAX)) begin
            w_tc = T_MAX;
        end else begin
            w_tc = $signed(w_t[9:0]);
        end
        // The clamp keeps the numerator positive, so the divide by 16 is a
        // plain shift and the gain lies in 40 to 72.
        w_gnum = GAIN_OFFSET - 12'(w_tc);
        w_gain = w_gnum[10:4];
    end

    // ------------------------------------------------------------------
    // Stage 3: per-byte scaling with saturation into the output register.
    // ------------------------------------------------------------------
    logic                 r3_v;
    logic [GAIN_W-1:0]    r3_gain;
    logic [COLOR_W-1:0]   r3_color;
    logic                 r3_fe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_gain  <= w_gain;
            r3_color <= r2_color;
            r3_fe    <= r2_fe;
        end
    end

    logic [COLOR_W-1:0] w_shaded;

    always_comb begin
        logic [14:0] prod;
        w_shaded = '0;
        prod     = '0;
        for (int k = 0; k < 4; k++) begin
            prod = 15'(r3_color[8*k +: 8]) * 15'(r3_gain);
            w_shaded[8*k +: 8] = (prod[14:6] > 9'd255) ? 8'hFF : prod[13:6];
        end
    end

    t_out_item r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data.shaded_color <= w_shaded;
            r_out_data.frame_end    <= r3_fe;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out_data;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The position in a scan never runs past the effective scan length.
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r_last_pos)
        else $error("scan position beyond scan length");

    // The scan counter stops at the scan count, where the flush scan runs.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan <= r_cnt)
        else $error("scan counter beyond scan count");

    // Items of the first scan only fill the lines and never start a result.
    a_first_scan_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_scan == '0)) |=> !r1_v)
        else $error("first scan item entered the pipeline");

    // A frame end can only leave the block during a flush scan's last pixel,
    // which also returns the scan counter to the top of the frame.
    a_frame_end_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && w_flush && w_last_pos && !i_cfg_valid) |=> (r_scan == '0))
        else $error("frame did not restart after the flush scan");

endmodule
